@@ sv/bvm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bvm_pkg;

   localparam int unsigned BURST_SAMPLES = 8;
   localparam int unsigned POS_W         = 3;
   localparam int unsigned RAW_W         = 14;
   localparam int unsigned SAMPLE_W      = 13;
   localparam int unsigned SUM4_W        = 15;
   localparam int unsigned MV_W          = 19;
   localparam int unsigned SUM_W         = 24;
   localparam int unsigned SCALE_SHIFT   = 13;
   localparam int unsigned COEF_HALF_W   = 12;
   localparam int unsigned CSR_INDEX_W   = 3;
   localparam int unsigned CSR_DATA_W    = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_CALIB_VREF  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VREF_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_MIN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORK_MIN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_COEF  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_FULL  = 3'd6;

   typedef struct packed {
      logic [RAW_W-1:0] raw_word;
      logic             start_check;
   } req_type;

   typedef struct packed {
      logic [MV_W-1:0] voltage_mv;
      logic [MV_W-1:0] mean_mv;
      logic [7:0]      charge_level;
      logic            low_batt;
      logic            average_updated;
   } rsp_type;

   typedef struct packed {
      logic [15:0]       calib_vref_mv;
      logic signed [7:0] vref_offset_mv;
      logic [15:0]       start_min_mv;
      logic [15:0]       work_min_mv;
      logic [15:0]       full_mv;
      logic [23:0]       level_coef;
      logic [7:0]        level_full;
   } cfg_type;

   typedef struct packed {
      logic [SUM4_W-1:0] sum4;
      logic              start_check;
   } burst_type;

endpackage
`default_nettype wire

@@ sv/battery_voltage_monitor_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Battery gauge on raw ADC words. The front end takes one word a cycle, holding an eighth word
// while the queue is full, and insertion-sorts it into an eight-entry set; at each eighth word
// the sum of the middle four goes into a two-deep queue and one result beat follows from the
// back end, which takes no new burst until the last beat is taken on rsp_ready. It has one
// shared 19x16 multiplier for scaling and the two-half level product, and a one-bit-a-cycle
// divider of 24 steps while fewer than 2**AVG_SHIFT bursts have been averaged (skipped once
// the leaky average runs, or on a failed start check). Register writes take effect at once.
module battery_voltage_monitor_unit #(
   parameter int unsigned AVG_SHIFT   = 5,
   parameter int unsigned LEVEL_SHIFT = 24
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  bvm_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output bvm_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [bvm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [bvm_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import bvm_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready;
   burst_type push_data;
   logic      pop_valid, pop_ready;
   burst_type pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CALIB_VREF:  cfg_in.calib_vref_mv  = csr_wdata[15:0];
            CSR_VREF_OFFSET: cfg_in.vref_offset_mv = csr_wdata[7:0];
            CSR_START_MIN:   cfg_in.start_min_mv   = csr_wdata[15:0];
            CSR_WORK_MIN:    cfg_in.work_min_mv    = csr_wdata[15:0];
            CSR_FULL:        cfg_in.full_mv        = csr_wdata[15:0];
            CSR_LEVEL_COEF:  cfg_in.level_coef     = csr_wdata[23:0];
            CSR_LEVEL_FULL:  cfg_in.level_full     = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.calib_vref_mv  <= 16'd1175;
         cfg_ff.vref_offset_mv <= 8'sd0;
         cfg_ff.start_min_mv   <= 16'd2200;
         cfg_ff.work_min_mv    <= 16'd2000;
         cfg_ff.full_mv        <= 16'd3000;
         cfg_ff.level_coef     <= 24'd1677721;
         cfg_ff.level_full     <= 8'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bvm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   bvm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bvm_back #(
      .AVG_SHIFT   (AVG_SHIFT),
      .LEVEL_SHIFT (LEVEL_SHIFT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ sv/bvm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bvm_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  bvm_pkg::req_type    req_data,
   output logic                push_valid,
   input  wire                 push_ready,
   output bvm_pkg::burst_type  push_data
);
   import bvm_pkg::*;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BURST_SAMPLES - 1);

   logic [SAMPLE_W-1:0] sorted_ff [BURST_SAMPLES];
   logic [SAMPLE_W-1:0] sorted_in [BURST_SAMPLES];
   logic [SAMPLE_W-1:0] prev_s    [BURST_SAMPLES];
   logic [BURST_SAMPLES-1:0] gt;
   logic [BURST_SAMPLES-1:0] prev_gt;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [SAMPLE_W-1:0] sample;
   logic                last_word;
   logic                accept;

   assign sample     = req_data.raw_word[RAW_W-1] ? '0 : req_data.raw_word[SAMPLE_W-1:0];
   assign last_word  = (pos_ff == LAST_POS);
   assign req_ready  = !last_word || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = req_valid && last_word;

   always_comb begin
      for (int i = 0; i < BURST_SAMPLES; i++) begin
         gt[i] = (sorted_ff[i] > sample);
      end
      prev_gt[0] = 1'b0;
      prev_s[0]  = sample;
      for (int i = 1; i < BURST_SAMPLES; i++) begin
         prev_gt[i] = gt[i-1];
         prev_s[i]  = sorted_ff[i-1];
      end
      for (int i = 0; i < BURST_SAMPLES; i++) begin
         if (POS_W'(i) < pos_ff && !gt[i]) begin
            sorted_in[i] = sorted_ff[i];
         end else if (POS_W'(i) <= pos_ff) begin
            sorted_in[i] = prev_gt[i] ? prev_s[i] : sample;
         end else begin
            sorted_in[i] = sorted_ff[i];
         end
      end
   end

   assign push_data.sum4 = SUM4_W'(sorted_in[2]) + SUM4_W'(sorted_in[3])
                         + SUM4_W'(sorted_in[4]) + SUM4_W'(sorted_in[5]);
   assign push_data.start_check = req_data.start_check;

   assign pos_in = accept ? (last_word ? '0 : pos_ff + 1'b1) : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < BURST_SAMPLES; i++) begin
            sorted_ff[i] <= sorted_in[i];
         end
      end
   end

endmodule
`default_nettype wire

@@ sv/bvm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bvm_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  bvm_pkg::burst_type  push_data,
   output logic                pop_valid,
   input  wire                 pop_ready,
   output bvm_pkg::burst_type  pop_data
);
   import bvm_pkg::*;

   burst_type   slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ sv/bvm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bvm_back #(
   parameter int unsigned AVG_SHIFT   = 5,
   parameter int unsigned LEVEL_SHIFT = 24
) (
   input  wire                 clock,
   input  wire                 reset,
   input  bvm_pkg::cfg_type    cfg,
   input  wire                 pop_valid,
   output logic                pop_ready,
   input  bvm_pkg::burst_type  pop_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output bvm_pkg::rsp_type    rsp_data
);
   import bvm_pkg::*;

   localparam int unsigned CNT_W   = AVG_SHIFT + 1;
   localparam int unsigned DCNT_W  = $clog2(SUM_W);
   localparam int unsigned MUL_A_W = MV_W;
   localparam int unsigned MUL_B_W = 16;
   localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
   localparam int unsigned LVL_W   = PROD_W + COEF_HALF_W + 1;
   localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(SUM_W - 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SCALE  = 4'd1;
   localparam logic [3:0] ST_VOLT   = 4'd2;
   localparam logic [3:0] ST_ACCUM  = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_LEVEL  = 4'd5;
   localparam logic [3:0] ST_MUL_LO = 4'd6;
   localparam logic [3:0] ST_MUL_HI = 4'd7;
   localparam logic [3:0] ST_SUM    = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   logic [3:0]           state_ff, state_in;
   logic [SUM4_W-1:0]    sum4_ff;
   logic                 start_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [PROD_W-1:0]    acc_ff;
   logic [MV_W-1:0]      vbat_ff;
   logic [MV_W-1:0]      avg_ff;
   logic [MV_W-1:0]      diff_ff;
   logic [SUM_W-1:0]     quo_ff;
   logic [AVG_SHIFT-1:0] rem_ff;
   logic [DCNT_W-1:0]    dcnt_ff;
   logic [SUM_W-1:0]     avg_sum_ff;
   logic [CNT_W-1:0]     avg_cnt_ff;
   logic [MV_W-1:0]      last_avg_ff;
   rsp_type              rsp_ff;

   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [PROD_W-1:0]    mul_p;
   logic signed [MV_W:0] volt_s;
   logic [MV_W-1:0]      vbat;
   logic [SUM_W:0]       sum_wide;
   logic [SUM_W-1:0]     sum_sat;
   logic [SUM_W-1:0]     sum_shr;
   logic [CNT_W-1:0]     cnt_next;
   logic [AVG_SHIFT:0]   rem_sh;
   logic                 rem_ge;
   logic [AVG_SHIFT:0]   rem_sub;
   logic [SUM_W-1:0]     quo_next;
   logic [LVL_W-1:0]     lvl_p;

   assign pop_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

   always_comb begin
      case (state_ff)
         ST_MUL_LO: begin
            mul_a = diff_ff;
            mul_b = MUL_B_W'(cfg.level_coef[COEF_HALF_W-1:0]);
         end
         ST_MUL_HI: begin
            mul_a = diff_ff;
            mul_b = MUL_B_W'(cfg.level_coef[2*COEF_HALF_W-1:COEF_HALF_W]);
         end
         default: begin
            mul_a = MUL_A_W'(sum4_ff);
            mul_b = cfg.calib_vref_mv;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      volt_s   = $signed({2'b00, prod_ff[SUM4_W+16-1:SCALE_SHIFT]})
               + (MV_W+1)'(cfg.vref_offset_mv);
      vbat     = volt_s[MV_W] ? '0 : volt_s[MV_W-1:0];
      sum_wide = {1'b0, avg_sum_ff} + (SUM_W+1)'(vbat_ff);
      sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      sum_shr  = sum_sat >> AVG_SHIFT;
      cnt_next = avg_cnt_ff + 1'b1;
      rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
      rem_ge   = (rem_sh >= avg_cnt_ff);
      rem_sub  = rem_sh - avg_cnt_ff;
      quo_next = {quo_ff[SUM_W-2:0], rem_ge};
      lvl_p    = LVL_W'(acc_ff) + LVL_W'({prod_ff, {COEF_HALF_W{1'b0}}});
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:  state_in = ST_VOLT;
         ST_VOLT: begin
            if (start_ff && (vbat < MV_W'(cfg.start_min_mv))) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            state_in = cnt_next[AVG_SHIFT] ? ST_LEVEL : ST_DIV;
         end
         ST_DIV: begin
            if (dcnt_ff == DIV_LAST) begin
               state_in = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            if (avg_ff >= MV_W'(cfg.full_mv) || avg_ff <= MV_W'(cfg.work_min_mv)) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_SUM;
         ST_SUM:    state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         avg_sum_ff  <= '0;
         avg_cnt_ff  <= '0;
         last_avg_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_ACCUM) begin
            if (cnt_next[AVG_SHIFT]) begin
               avg_sum_ff <= sum_sat - sum_shr;
            end else begin
               avg_sum_ff <= sum_sat;
               avg_cnt_ff <= cnt_next;
            end
         end
         if (state_ff == ST_LEVEL) begin
            last_avg_ff <= avg_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            sum4_ff  <= pop_data.sum4;
            start_ff <= pop_data.start_check;
         end
         ST_SCALE: begin
            prod_ff <= mul_p;
         end
         ST_VOLT: begin
            vbat_ff                 <= vbat;
            rsp_ff.voltage_mv       <= vbat;
            rsp_ff.mean_mv          <= last_avg_ff;
            rsp_ff.charge_level     <= '0;
            rsp_ff.low_batt         <= 1'b1;
            rsp_ff.average_updated  <= 1'b0;
         end
         ST_ACCUM: begin
            avg_ff  <= sum_shr[MV_W-1:0];
            quo_ff  <= sum_sat;
            rem_ff  <= '0;
            dcnt_ff <= '0;
         end
         ST_DIV: begin
            quo_ff  <= quo_next;
            rem_ff  <= rem_ge ? rem_sub[AVG_SHIFT-1:0] : rem_sh[AVG_SHIFT-1:0];
            dcnt_ff <= dcnt_ff + 1'b1;
            avg_ff  <= quo_next[MV_W-1:0];
         end
         ST_LEVEL: begin
            diff_ff                <= avg_ff - MV_W'(cfg.work_min_mv);
            rsp_ff.mean_mv         <= avg_ff;
            rsp_ff.average_updated <= 1'b1;
            if (avg_ff >= MV_W'(cfg.full_mv)) begin
               rsp_ff.charge_level <= cfg.level_full;
               rsp_ff.low_batt     <= 1'b0;
            end else if (avg_ff <= MV_W'(cfg.work_min_mv)) begin
               rsp_ff.charge_level <= '0;
               rsp_ff.low_batt     <= 1'b1;
            end else begin
               rsp_ff.low_batt     <= 1'b0;
            end
         end
         ST_MUL_LO: begin
            prod_ff <= mul_p;
         end
         ST_MUL_HI: begin
            acc_ff  <= prod_ff;
            prod_ff <= mul_p;
         end
         ST_SUM: begin
            rsp_ff.charge_level <= lvl_p[LEVEL_SHIFT +: 8];
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

@@ sv/bvm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bvm_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input bvm_pkg::rsp_type  rsp_data
);
   import bvm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   a_start_fail_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.average_updated |-> rsp_data.low_batt)
      else $error("failed start check without low power");

   a_start_fail_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.average_updated |-> rsp_data.charge_level == 8'd0)
      else $error("failed start check with nonzero level");

   a_low_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.low_batt |-> rsp_data.charge_level == 8'd0)
      else $error("low power with nonzero level");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind battery_voltage_monitor_unit bvm_checker u_bvm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import bvm_pkg::*;

   localparam int unsigned AVG_SHIFT     = 5;
   localparam int unsigned LEVEL_SHIFT   = 24;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned MAX_WAIT      = 19;
   localparam int unsigned REPORT_LINES  = 40;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // gauge predictor state
   cfg_type             gauge_cfg;
   logic [SAMPLE_W-1:0] burst_set [BURST_SAMPLES];
   int unsigned         burst_fill;
   logic [31:0]         avg_sum;
   int unsigned         avg_count;
   logic [MV_W-1:0]     last_avg;
   rsp_type             gauge_q [$];

   bit          steady_in  = 1'b0;
   bit          steady_out = 1'b0;
   int unsigned stall_left = 0;
   int unsigned fail_count = 0;
   int unsigned words_sent = 0;
   int unsigned beats_checked = 0;
   int unsigned csr_writes = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   battery_voltage_monitor_unit #(
      .AVG_SHIFT   (AVG_SHIFT),
      .LEVEL_SHIFT (LEVEL_SHIFT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic bit predict_burst(input req_type word, output rsp_type res);
      logic [SAMPLE_W-1:0] sample;
      int                  k;
      logic [SUM4_W-1:0]   sum4;
      longint              volt;
      logic [31:0]         vbat;
      logic [31:0]         avg;
      logic [63:0]         level_prod;
      res = '0;
      sample = word.raw_word[RAW_W-1] ? '0 : word.raw_word[SAMPLE_W-1:0];
      k = burst_fill;
      while (k > 0 && burst_set[k-1] > sample) begin
         burst_set[k] = burst_set[k-1];
         k--;
      end
      burst_set[k] = sample;
      if (burst_fill < BURST_SAMPLES - 1) begin
         burst_fill++;
         return 1'b0;
      end
      burst_fill = 0;
      sum4 = SUM4_W'(burst_set[2]) + SUM4_W'(burst_set[3])
           + SUM4_W'(burst_set[4]) + SUM4_W'(burst_set[5]);
      volt = longint'((64'(sum4) * 64'(gauge_cfg.calib_vref_mv)) >> SCALE_SHIFT)
           + longint'($signed(gauge_cfg.vref_offset_mv));
      vbat = (volt < 0) ? 32'd0 : 32'(volt);
      res.voltage_mv = vbat[MV_W-1:0];
      if (word.start_check && vbat < 32'(gauge_cfg.start_min_mv)) begin
         res.mean_mv  = last_avg;
         res.low_batt = 1'b1;
         return 1'b1;
      end
      avg_sum = avg_sum + vbat;
      if (avg_sum > 32'hFF_FFFF)
         avg_sum = 32'hFF_FFFF;
      avg_count++;
      if (avg_count >= (1 << AVG_SHIFT)) begin
         avg = avg_sum >> AVG_SHIFT;
         avg_sum = avg_sum - avg;
         avg_count--;
      end else begin
         avg = avg_sum / avg_count;
      end
      last_avg = avg[MV_W-1:0];
      res.mean_mv         = last_avg;
      res.average_updated = 1'b1;
      if (last_avg >= gauge_cfg.full_mv) begin
         res.charge_level = gauge_cfg.level_full;
      end else if (last_avg > gauge_cfg.work_min_mv) begin
         level_prod = 64'(last_avg - gauge_cfg.work_min_mv) * 64'(gauge_cfg.level_coef);
         res.charge_level = level_prod[LEVEL_SHIFT +: 8];
      end else begin
         res.low_batt = 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic cfg_type draw_settings();
      cfg_type s;
      s.calib_vref_mv  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(900, 1500));
      s.vref_offset_mv = 8'($urandom);
      s.start_min_mv   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(1000, 4000));
      s.work_min_mv    = 16'($urandom_range(1000, 3000));
      s.full_mv        = 16'($urandom_range(2000, 5000));
      s.level_coef     = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 4000000));
      s.level_full     = 8'($urandom);
      return s;
   endfunction

   task automatic report_error(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LINES)
         $display("[%0t] ERROR %s", $time, msg);
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want)
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic send_word(input logic [RAW_W-1:0] raw, input logic start);
      int      gap;
      rsp_type res;
      gap = steady_in ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = '{raw_word: raw, start_check: start};
      do @(posedge clock); while (!req_ready);
      if (predict_burst(req_data, res))
         gauge_q.push_back(res);
      words_sent++;
   endtask

   task automatic send_random_burst(input int unsigned low, input int unsigned high);
      int unsigned centre;
      bit          noisy;
      centre = $urandom_range(low, high);
      noisy  = ($urandom_range(0, 7) == 0);
      for (int i = 0; i < BURST_SAMPLES; i++) begin
         int               v;
         logic [RAW_W-1:0] raw;
         v = int'(centre) + int'($urandom_range(0, 256)) - 128;
         if (v < 0)
            v = 0;
         if (v > 8191)
            v = 8191;
         raw = RAW_W'(v);
         if (noisy)
            raw = RAW_W'($urandom);
         else if ($urandom_range(0, 15) == 0)
            raw = {1'b1, 13'($urandom)};
         send_word(raw, 1'($urandom));
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_CALIB_VREF:  gauge_cfg.calib_vref_mv  = value[15:0];
         CSR_VREF_OFFSET: gauge_cfg.vref_offset_mv = value[7:0];
         CSR_START_MIN:   gauge_cfg.start_min_mv   = value[15:0];
         CSR_WORK_MIN:    gauge_cfg.work_min_mv    = value[15:0];
         CSR_FULL:        gauge_cfg.full_mv        = value[15:0];
         CSR_LEVEL_COEF:  gauge_cfg.level_coef     = value[23:0];
         CSR_LEVEL_FULL:  gauge_cfg.level_full     = value[7:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // upper bits are random, so the width truncation is exercised on every load
   task automatic load_settings(input cfg_type s);
      write_reg(CSR_CALIB_VREF,  {8'($urandom), s.calib_vref_mv});
      write_reg(CSR_VREF_OFFSET, {16'($urandom), s.vref_offset_mv});
      write_reg(CSR_START_MIN,   {8'($urandom), s.start_min_mv});
      write_reg(CSR_WORK_MIN,    {8'($urandom), s.work_min_mv});
      write_reg(CSR_FULL,        {8'($urandom), s.full_mv});
      write_reg(CSR_LEVEL_COEF,  s.level_coef);
      write_reg(CSR_LEVEL_FULL,  {16'($urandom), s.level_full});
      write_reg(CSR_SPARE,       24'($urandom));
   endtask

   // drop valid, drain outstanding beats, then let the back end go quiet
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (gauge_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_values();
      logic [RAW_W-1:0] extremes [BURST_SAMPLES];
      extremes = '{14'h0000, 14'h1FFF, 14'h3FFF, 14'h2000,
                   14'h0001, 14'h1FFE, 14'h1000, 14'h1FFF};
      // start flag on early words only: must be ignored
      foreach (extremes[i])
         send_word(extremes[i], (i != BURST_SAMPLES - 1) && i[0]);
      for (int i = 0; i < BURST_SAMPLES; i++)
         send_word(14'd1000, i == BURST_SAMPLES - 1);
      for (int i = 0; i < BURST_SAMPLES; i++)
         send_word(14'h1FFF, i == BURST_SAMPLES - 1);
   endtask

   task automatic test_register_extremes();
      cfg_type corners [3];
      corners[0] = '{calib_vref_mv: 16'd0, vref_offset_mv: 8'sh80, start_min_mv: 16'd0,
                     work_min_mv: 16'd0, full_mv: 16'd0, level_coef: 24'd0,
                     level_full: 8'd0};
      corners[1] = '{calib_vref_mv: 16'hFFFF, vref_offset_mv: 8'sh7F,
                     start_min_mv: 16'hFFFF, work_min_mv: 16'hFFFF, full_mv: 16'hFFFF,
                     level_coef: 24'hFF_FFFF, level_full: 8'hFF};
      corners[2] = '{calib_vref_mv: 16'd1175, vref_offset_mv: 8'sd0,
                     start_min_mv: 16'd2200, work_min_mv: 16'd3000, full_mv: 16'd2000,
                     level_coef: 24'd1677721, level_full: 8'd100};
      foreach (corners[c]) begin
         settle();
         load_settings(corners[c]);
         send_random_burst(0, 8191);
         send_random_burst(7000, 8191);
         send_random_burst(0, 1500);
      end
   endtask

   task automatic test_full_scale();
      cfg_type s;
      s = '{calib_vref_mv: 16'hFFFF, vref_offset_mv: 8'sh7F, start_min_mv: 16'hFFFF,
            work_min_mv: 16'd0, full_mv: 16'hFFFF, level_coef: 24'hFF_FFFF,
            level_full: 8'hFF};
      settle();
      load_settings(s);
      steady_in = 1'b1;
      repeat (18) send_random_burst(7900, 8191);
      s.calib_vref_mv  = 16'd15000;
      s.vref_offset_mv = 8'sh80;
      settle();
      load_settings(s);
      steady_in  = 1'b0;
      steady_out = 1'b1;
      repeat (18) send_random_burst(7900, 8191);
      steady_out = 1'b0;
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         settle();
         load_settings(draw_settings());
         steady_in  = (phase % 3 == 1);
         steady_out = (phase % 4 == 2);
         repeat (11) send_random_burst(0, 8191);
      end
      steady_in  = 1'b0;
      steady_out = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_ready = (stall_left == 0);
      if (stall_left != 0)
         stall_left--;
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (gauge_q.size() == 0) begin
            report_error($sformatf("result beat with nothing expected: %p", rsp_data));
         end else begin
            want = gauge_q.pop_front();
            check_field("voltage_mv", rsp_data.voltage_mv, want.voltage_mv);
            check_field("mean_mv", rsp_data.mean_mv, want.mean_mv);
            check_field("charge_level", rsp_data.charge_level, want.charge_level);
            check_field("low_batt", rsp_data.low_batt, want.low_batt);
            check_field("average_updated", rsp_data.average_updated, want.average_updated);
         end
         stall_left = steady_out ? 0 : $urandom_range(0, MAX_WAIT);
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("no handshake for %0d cycles", STALL_LIMIT);
      $display("tb_top failed");
      $finish;
   end

   initial begin
      gauge_cfg = '{calib_vref_mv: 16'd1175, vref_offset_mv: 8'sd0,
                    start_min_mv: 16'd2200, work_min_mv: 16'd2000, full_mv: 16'd3000,
                    level_coef: 24'd1677721, level_full: 8'd100};
      burst_fill = 0;
      avg_sum    = '0;
      avg_count  = 0;
      last_avg   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_values();
      test_register_extremes();
      test_full_scale();
      test_random_traffic();
      settle();
      $display("Sent %0d ADC words over corner and random register settings,", words_sent);
      $display("checked %0d burst results, made %0d register writes, %0d mismatches.",
               beats_checked, csr_writes, fail_count);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/bvm_pkg.sv
sv/bvm_front.sv
sv/bvm_queue.sv
sv/bvm_back.sv
sv/battery_voltage_monitor_unit.sv
sv/bvm_checker.sv
tb/sv/tb_top.sv
